// ----- rtl/core/yst_pkg.sv -----
// Shared types, constants and helper functions for the YAML subset tokenizer.
// Used by every module under rtl/core; depends on nothing else.
package yst_pkg;

    localparam int POSITION_BITS = 24;
    localparam int LINE_BITS     = 16;
    localparam int DEPTH_BITS    = 8;
    localparam int INDENT_BITS   = 16;
    localparam int MAX_TOKENS    = 4;
    localparam int QUEUE_DEPTH   = 4;

    localparam logic [POSITION_BITS-1:0] POS_MAX    = '1;
    localparam logic [LINE_BITS-1:0]     LIN_MAX    = '1;
    localparam logic [INDENT_BITS-1:0]   INDENT_MAX = '1;
    localparam logic signed [DEPTH_BITS-1:0] DEP_MAX = {1'b0, {(DEPTH_BITS-1){1'b1}}};
    localparam logic signed [DEPTH_BITS-1:0] DEP_MIN = {1'b1, {(DEPTH_BITS-1){1'b0}}};

    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_TILDE  = 8'h7E;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_NUL    = 8'h00;

    typedef enum logic [2:0] {
        ST_IDLE    = 3'd0,
        ST_INDENT  = 3'd1,
        ST_COMMENT = 3'd2,
        ST_SCALAR  = 3'd3,
        ST_VAROPEN = 3'd4,
        ST_VARREF  = 3'd5
    } scan_state_t;

    typedef enum logic [3:0] {
        K_INDENT  = 4'd0,
        K_NEWLINE = 4'd1,
        K_LBRACE  = 4'd2,
        K_RBRACE  = 4'd3,
        K_COMMA   = 4'd4,
        K_COLON   = 4'd5,
        K_DASH    = 4'd6,
        K_NULL    = 4'd7,
        K_VARREF  = 4'd8,
        K_SCALAR  = 4'd9,
        K_EOF     = 4'd10,
        K_ERROR   = 4'd11
    } tok_kind_t;

    typedef struct packed {
        tok_kind_t                kind;
        logic [LINE_BITS-1:0]     line;
        logic [LINE_BITS-1:0]     column;
        logic [INDENT_BITS-1:0]   indent;
        logic [POSITION_BITS-1:0] offset;
        logic [POSITION_BITS-1:0] length;
    } token_t;

    // All tokens caused by one input item; count is never zero in the queue.
    typedef struct packed {
        logic [2:0] count;
        token_t [MAX_TOKENS-1:0] tok;
    } bundle_t;

    typedef struct packed {
        logic [7:0]               la_byte;
        logic                     la_valid;
        logic [LINE_BITS-1:0]     line;
        logic [LINE_BITS-1:0]     column;
        logic [POSITION_BITS-1:0] pos;
        logic signed [DEPTH_BITS-1:0] depth;
        logic                     at_bol;
        scan_state_t              st;
        logic [LINE_BITS-1:0]     sp_line;
        logic [LINE_BITS-1:0]     sp_column;
        logic [POSITION_BITS-1:0] sp_offset;
        logic [POSITION_BITS-1:0] sp_end;
        logic [INDENT_BITS-1:0]   spaces;
    } lex_state_t;

    localparam lex_state_t LEX_RESET = '{
        la_byte: 8'd0, la_valid: 1'b0, line: LINE_BITS'(1), column: LINE_BITS'(1),
        pos: '0, depth: '0, at_bol: 1'b1, st: ST_IDLE, sp_line: '0,
        sp_column: '0, sp_offset: '0, sp_end: '0, spaces: '0};

    function automatic logic is_white(input logic [7:0] c);
        is_white = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NL) ||
                   (c == CH_VT) || (c == CH_FF) || (c == CH_CR);
    endfunction

    function automatic logic [POSITION_BITS-1:0] pos_inc(input logic [POSITION_BITS-1:0] p);
        pos_inc = (p < POS_MAX) ? p + 1'b1 : POS_MAX;
    endfunction

endpackage

// ----- rtl/core/yst_front.sv -----
// Front end of the tokenizer: holds the lexer state and turns each accepted
// byte or end marker into a bundle of up to four tokens. Depends on yst_pkg.
module yst_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fire,
    input  logic                 mode,
    input  logic [7:0]           data_byte,
    output logic                 push,
    output yst_pkg::bundle_t     bundle
);
    import yst_pkg::*;

    lex_state_t state_reg, state_next;

    function automatic lex_state_t adv(input lex_state_t s, input logic [7:0] b);
        lex_state_t r;
        r = s;
        r.pos = pos_inc(s.pos);
        if (b == CH_NL) begin
            r.line   = (s.line < LIN_MAX) ? s.line + 1'b1 : LIN_MAX;
            r.column = LINE_BITS'(1);
        end
        else if (s.column < LIN_MAX) begin
            r.column = s.column + 1'b1;
        end
        return r;
    endfunction

    function automatic lex_state_t take(input lex_state_t s, input logic [7:0] b);
        lex_state_t r;
        r = s;
        if (b != CH_SPACE && b != CH_TAB) r.sp_end = pos_inc(s.pos);
        return adv(r, b);
    endfunction

    function automatic bundle_t emit(input bundle_t bd, input tok_kind_t k,
                                     input logic [LINE_BITS-1:0] ln,
                                     input logic [LINE_BITS-1:0] col,
                                     input logic [INDENT_BITS-1:0] ind,
                                     input logic [POSITION_BITS-1:0] off,
                                     input logic [POSITION_BITS-1:0] len);
        bundle_t r;
        r = bd;
        if (bd.count < 3'(MAX_TOKENS)) begin
            r.tok[bd.count[1:0]] = '{kind: k, line: ln, column: col, indent: ind,
                                     offset: off, length: len};
            r.count = bd.count + 1'b1;
        end
        return r;
    endfunction

    function automatic logic [POSITION_BITS-1:0] span_len(input lex_state_t s,
                                                         input logic [POSITION_BITS-1:0] e);
        span_len = (e > s.sp_offset) ? e - s.sp_offset : '0;
    endfunction

    always_comb
    begin
        lex_state_t s;
        bundle_t    bd;
        logic [7:0] b;
        logic [7:0] nx;
        logic       go;
        logic       dn;
        logic       stop;
        logic       failed;
        s      = state_reg;
        bd     = '0;
        b      = s.la_byte;
        nx     = mode ? CH_NUL : data_byte;
        go     = 1'b0;
        dn     = 1'b0;
        stop   = 1'b0;
        failed = 1'b0;
        if (fire) begin
            if (s.la_valid) begin
                go = 1'b1;
                unique case (s.st)
                    ST_INDENT:
                    begin
                        if (b == CH_SPACE) begin
                            if (s.spaces != INDENT_MAX) s.spaces = s.spaces + 1'b1;
                            s  = adv(s, b);
                            go = 1'b0;
                        end
                        else begin
                            bd = emit(bd, K_INDENT, s.sp_line, s.sp_column, s.spaces, '0, '0);
                            s.at_bol = 1'b0;
                            s.st = ST_IDLE;
                        end
                    end
                    ST_COMMENT:
                    begin
                        if (b != CH_NL) begin
                            s  = adv(s, b);
                            go = 1'b0;
                        end
                        else begin
                            s.st = ST_IDLE;
                        end
                    end
                    ST_SCALAR:
                    begin
                        stop = (b == CH_NL) || (b == CH_HASH) ||
                               (s.depth != 0 && (b == CH_COMMA || b == CH_RBRACE)) ||
                               (s.depth == 0 && b == CH_COLON && (mode || is_white(nx)));
                        if (!stop) begin
                            s  = take(s, b);
                            go = 1'b0;
                        end
                        else begin
                            if (span_len(s, s.sp_end) != '0)
                                bd = emit(bd, K_SCALAR, s.sp_line, s.sp_column, '0,
                                          s.sp_offset, span_len(s, s.sp_end));
                            s.st = ST_IDLE;
                        end
                    end
                    ST_VAROPEN:
                    begin
                        s.sp_offset = pos_inc(s.pos);
                        s.st = ST_VARREF;
                        s  = adv(s, b);
                        go = 1'b0;
                    end
                    ST_VARREF:
                    begin
                        if (b == CH_RBRACE) begin
                            bd = emit(bd, K_VARREF, s.sp_line, s.sp_column, '0,
                                      s.sp_offset, span_len(s, s.pos));
                            s.st = ST_IDLE;
                        end
                        s  = adv(s, b);
                        go = 1'b0;
                    end
                    default:
                    begin
                        s.st = ST_IDLE;
                    end
                endcase

                if (go) begin
                    if (s.at_bol && s.depth == 0) begin
                        s.sp_line   = s.line;
                        s.sp_column = s.column;
                        s.spaces    = '0;
                        if (b == CH_SPACE) begin
                            s.st     = ST_INDENT;
                            s.spaces = INDENT_BITS'(1);
                            s  = adv(s, b);
                            dn = 1'b1;
                        end
                        else begin
                            bd = emit(bd, K_INDENT, s.sp_line, s.sp_column, s.spaces, '0, '0);
                            s.at_bol = 1'b0;
                            s.st = ST_IDLE;
                        end
                    end
                    if (!dn) begin
                        case (b) inside
                            CH_NL:
                            begin
                                if (s.depth == 0)
                                    bd = emit(bd, K_NEWLINE, s.line, s.column, '0, '0, '0);
                                s.at_bol = 1'b1;
                                s  = adv(s, b);
                                dn = 1'b1;
                            end
                            CH_SPACE, CH_TAB:
                            begin
                                s  = adv(s, b);
                                dn = 1'b1;
                            end
                            CH_HASH:
                            begin
                                s.st = ST_COMMENT;
                                s  = adv(s, b);
                                dn = 1'b1;
                            end
                            CH_LBRACE:
                            begin
                                bd = emit(bd, K_LBRACE, s.line, s.column, '0, '0, '0);
                                if (s.depth < DEP_MAX)
                                    s.depth = s.depth + $signed(DEPTH_BITS'(1));
                                s  = adv(s, b);
                                dn = 1'b1;
                            end
                            CH_RBRACE:
                            begin
                                bd = emit(bd, K_RBRACE, s.line, s.column, '0, '0, '0);
                                if (s.depth > DEP_MIN)
                                    s.depth = s.depth - $signed(DEPTH_BITS'(1));
                                s  = adv(s, b);
                                dn = 1'b1;
                            end
                            CH_COMMA:
                            begin
                                bd = emit(bd, K_COMMA, s.line, s.column, '0, '0, '0);
                                s  = adv(s, b);
                                dn = 1'b1;
                            end
                            CH_COLON:
                            begin
                                if (s.depth != 0 || mode || nx == CH_NUL || is_white(nx)) begin
                                    bd = emit(bd, K_COLON, s.line, s.column, '0, '0, '0);
                                    s  = adv(s, b);
                                    dn = 1'b1;
                                end
                            end
                            CH_DASH:
                            begin
                                if (!mode && nx == CH_SPACE && s.depth == 0) begin
                                    bd = emit(bd, K_DASH, s.line, s.column, '0, '0, '0);
                                    s  = adv(s, b);
                                    dn = 1'b1;
                                end
                            end
                            CH_TILDE:
                            begin
                                if (mode || nx == CH_NUL || nx == CH_COMMA ||
                                    nx == CH_RBRACE || is_white(nx)) begin
                                    bd = emit(bd, K_NULL, s.line, s.column, '0, '0, '0);
                                    s  = adv(s, b);
                                    dn = 1'b1;
                                end
                            end
                            CH_DOLLAR:
                            begin
                                if (!mode && nx == CH_LBRACE) begin
                                    s.sp_line   = s.line;
                                    s.sp_column = s.column;
                                    s.st = ST_VAROPEN;
                                    s  = adv(s, b);
                                    dn = 1'b1;
                                end
                            end
                            default:
                            begin
                                dn = 1'b0;
                            end
                        endcase
                    end
                    if (!dn) begin
                        s.sp_line   = s.line;
                        s.sp_column = s.column;
                        s.sp_offset = s.pos;
                        s.sp_end    = s.pos;
                        s.st = ST_SCALAR;
                        s = take(s, b);
                    end
                end
            end

            if (!mode) begin
                s.la_byte  = data_byte;
                s.la_valid = 1'b1;
            end
            else begin
                if (s.st == ST_INDENT) begin
                    bd = emit(bd, K_INDENT, s.sp_line, s.sp_column, s.spaces, '0, '0);
                end
                else if (s.st == ST_SCALAR) begin
                    if (span_len(s, s.sp_end) != '0)
                        bd = emit(bd, K_SCALAR, s.sp_line, s.sp_column, '0,
                                  s.sp_offset, span_len(s, s.sp_end));
                end
                else if (s.st == ST_VAROPEN || s.st == ST_VARREF) begin
                    bd = emit(bd, K_ERROR, s.sp_line, s.sp_column, '0, '0, '0);
                    failed = 1'b1;
                end
                if (!failed) bd = emit(bd, K_EOF, s.line, s.column, '0, '0, '0);
                s = LEX_RESET;
            end
        end
        state_next = s;
        bundle     = bd;
        push       = fire && (bd.count != 3'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) state_reg <= LEX_RESET;
        else        state_reg <= state_next;
    end

endmodule

// ----- rtl/core/yst_queue.sv -----
// Short queue of token bundles between the front and back ends.
// Depends on yst_pkg.
module yst_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  yst_pkg::bundle_t wr_data,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output yst_pkg::bundle_t rd_data
);
    import yst_pkg::*;

    localparam int PTR_BITS = $clog2(QUEUE_DEPTH);

    bundle_t [QUEUE_DEPTH-1:0] slot_reg;
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_BITS:0]   fill_reg, fill_next;

    assign full      = (fill_reg == (PTR_BITS+1)'(QUEUE_DEPTH));
    assign not_empty = (fill_reg != '0);
    assign rd_data   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg + (PTR_BITS+1)'(push) - (PTR_BITS+1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push) slot_reg[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

// ----- rtl/core/yst_back.sv -----
// Back end of the tokenizer: takes one bundle at a time from the queue and
// sends its tokens out one per transfer. Depends on yst_pkg.
module yst_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_not_empty,
    input  yst_pkg::bundle_t q_data,
    output logic             q_pop,
    output logic             out_valid,
    input  logic             out_ready,
    output yst_pkg::token_t  out_token,
    output logic             out_last
);
    import yst_pkg::*;

    bundle_t    bundle_reg;
    logic [1:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    logic       fire;

    assign out_valid = valid_reg;
    assign out_token = bundle_reg.tok[idx_reg];
    assign out_last  = ({1'b0, idx_reg} == bundle_reg.count - 1'b1);
    assign fire      = valid_reg && out_ready;
    assign q_pop     = q_not_empty && (!valid_reg || (fire && out_last));

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (q_pop) begin
            idx_next   = '0;
            valid_next = 1'b1;
        end
        else if (fire) begin
            if (out_last) valid_next = 1'b0;
            else          idx_next   = idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop) bundle_reg <= q_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

endmodule

// ----- rtl/core/yaml_subset_tokenizer.sv -----
// Top level of the YAML subset tokenizer: front end, bundle queue, back end.
// Depends on yst_pkg, yst_front, yst_queue and yst_back.
//
// The tokenizer takes one document byte per transfer on the slave side
// (tuser low) or an end-of-document marker (tuser high), and sends tokens on
// the master side. A byte is decided one transfer late, when the following
// byte or the end marker is known. The front end accepts one input transfer
// every cycle while the four-entry bundle queue has room, and all per-byte
// work is done in that single cycle. The back end sends one token per cycle
// while m_tready is high, so an input that causes n tokens (at most four)
// takes n master transfers; input throughput is one byte per cycle whenever
// the output keeps up, and the queue absorbs short bursts of multi-token
// items. The last token caused by each input transfer carries tlast. Scalar
// and reference text is given as a byte offset and length, with trailing
// blanks trimmed from scalars. After the end marker the lexer state resets.
module yaml_subset_tokenizer (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // data_byte[7:0]
    input  logic         s_tuser,   // mode[0]
    output logic         m_tvalid,
    input  logic         m_tready,
    // token_kind[3:0], token_line[19:4], token_column[35:20],
    // indent_count[51:36], text_offset[75:52], text_length[99:76], zero[103:100]
    output logic [103:0] m_tdata,
    output logic         m_tlast    // last_of_run
);
    import yst_pkg::*;

    logic    in_fire;
    logic    push;
    logic    q_full;
    logic    q_not_empty;
    logic    q_pop;
    bundle_t push_bundle;
    bundle_t head_bundle;
    token_t  out_token;

    assign s_tready = !q_full;
    assign in_fire  = s_tvalid && s_tready;

    yst_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (in_fire),
        .mode      (s_tuser),
        .data_byte (s_tdata),
        .push      (push),
        .bundle    (push_bundle)
    );

    yst_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .wr_data   (push_bundle),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .rd_data   (head_bundle)
    );

    yst_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_data      (head_bundle),
        .q_pop       (q_pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_token   (out_token),
        .out_last    (m_tlast)
    );

    assign m_tdata = {4'b0000, out_token.length, out_token.offset, out_token.indent,
                      out_token.column, out_token.line, out_token.kind};

endmodule
